[hdl/matrix_multiply_accumulate_defines.svh]
// Assertion macros for the matrix multiply-accumulate block.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef MATRIX_MULTIPLY_ACCUMULATE_DEFINES_SVH
`define MATRIX_MULTIPLY_ACCUMULATE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MMA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MMA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/mma_pkg.sv]
// Shared types and constants for the matrix multiply-accumulate block.
// No dependencies; imported by mma_fma and the top level.
`default_nettype none
package mma_pkg;

	typedef logic signed [13:0] exp_t;

	typedef enum logic [2:0] {
		OP_WR_A     = 3'd0,
		OP_WR_B     = 3'd1,
		OP_WR_C     = 3'd2,
		OP_COMPUTE  = 3'd3,
		OP_RD_C     = 3'd4
	} op_t;

	localparam logic [63:0] DEFAULT_NAN = 64'h7FF8_0000_0000_0000;
	localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] c;
	} fma_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] res;
	} fma_rsp_t;

endpackage
`default_nettype wire

[hdl/mma_fma.sv]
// Iterative binary64 fused multiply-add a*b+c, round to nearest even.
// Depends on mma_pkg for the request and response words.
`default_nettype none
module mma_fma (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mma_pkg::fma_req_t req,
	output mma_pkg::fma_rsp_t      rsp
);
	import mma_pkg::*;

	typedef enum logic [7:0] {
		F_IDLE = 8'b0000_0001,
		F_UNP  = 8'b0000_0010,
		F_MUL  = 8'b0000_0100,
		F_ALN  = 8'b0000_1000,
		F_ADD  = 8'b0001_0000,
		F_FIX  = 8'b0010_0000,
		F_NRM  = 8'b0100_0000,
		F_RND  = 8'b1000_0000
	} fstate_t;

	fstate_t state_q;
	logic [2:0]   cnt_q;
	logic [52:0]  ma_q, mb_q, mc_q;
	exp_t         ea_q, eb_q, ec_q, e_q;
	logic         sp_q, sc_q, czero_q, sub_q;
	logic [55:0]  mbsh_q;
	logic [127:0] acc_q, cs_q, sig_q;
	logic [128:0] sum_q;
	logic         done_q;
	logic [63:0]  res_q;

	function automatic logic f_nan(input logic [63:0] x);
		f_nan = (&x[62:52]) && (|x[51:0]);
	endfunction

	function automatic logic f_inf(input logic [63:0] x);
		f_inf = (&x[62:52]) && !(|x[51:0]);
	endfunction

	function automatic logic f_zero(input logic [63:0] x);
		f_zero = !(|x[62:0]);
	endfunction

	function automatic logic [127:0] shr_jam(input logic [127:0] x, input logic [7:0] d);
		logic [127:0] r;
		logic [127:0] mask;
		r    = x >> d;
		mask = ~({128{1'b1}} << d);
		r[0] = r[0] | (|(x & mask));
		shr_jam = r;
	endfunction

	// Special operands settle the result without the datapath.
	logic        spec_hit;
	logic [63:0] spec_res;
	logic        sp_in, sc_in;
	always_comb begin
		sp_in    = req.a[63] ^ req.b[63];
		sc_in    = req.c[63];
		spec_hit = 1'b1;
		spec_res = '0;
		if (f_nan(req.a)) begin
			spec_res = req.a | QUIET_BIT;
		end else if (f_nan(req.b)) begin
			spec_res = req.b | QUIET_BIT;
		end else if (f_nan(req.c)) begin
			spec_res = req.c | QUIET_BIT;
		end else if (f_inf(req.a) || f_inf(req.b)) begin
			if (f_zero(req.a) || f_zero(req.b)) begin
				spec_res = DEFAULT_NAN;
			end else if (f_inf(req.c) && (sc_in != sp_in)) begin
				spec_res = DEFAULT_NAN;
			end else begin
				spec_res = {sp_in, 11'h7FF, 52'd0};
			end
		end else if (f_inf(req.c)) begin
			spec_res = req.c;
		end else if (f_zero(req.a) || f_zero(req.b)) begin
			if (!f_zero(req.c)) begin
				spec_res = req.c;
			end else begin
				spec_res = (sp_in == sc_in) ? {sp_in, 63'd0} : 64'd0;
			end
		end else begin
			spec_hit = 1'b0;
		end
	end

	// Alignment of product and addend.
	logic [127:0] p_al, c_al, jam_in, jammed;
	exp_t         ep_al, ecs_al, d_full;
	logic         p_ge;
	logic [7:0]   d8;
	always_comb begin
		p_al   = acc_q << 20;
		ep_al  = ea_q + eb_q - exp_t'(20);
		c_al   = {3'd0, mc_q, 72'd0};
		ecs_al = ec_q - exp_t'(72);
		p_ge   = ep_al >= ecs_al;
		d_full = p_ge ? (ep_al - ecs_al) : (ecs_al - ep_al);
		d8     = (d_full > exp_t'(255)) ? 8'd255 : d_full[7:0];
		jam_in = p_ge ? c_al : p_al;
		jammed = shr_jam(jam_in, d8);
	end

	logic sign_q;
	logic sign_q_w;
	assign sign_q_w = sign_q;

	// Final rounding of a significand normalized to bit 127.
	exp_t         t_r, tc_r, s_r, tn_r, biased_r;
	logic [7:0]   s8, sm1;
	logic [127:0] shifted, smask;
	logic         guard, sticky;
	logic [53:0]  qr, qn;
	logic [63:0]  rnd_res;
	always_comb begin
		t_r     = e_q + exp_t'(75);
		tc_r    = (t_r < exp_t'(-1074)) ? exp_t'(-1074) : t_r;
		s_r     = tc_r - e_q;
		s8      = (s_r > exp_t'(255)) ? 8'd255 : s_r[7:0];
		sm1     = s8 - 8'd1;
		shifted = sig_q >> sm1;
		guard   = shifted[0];
		smask   = (128'd1 << sm1) - 128'd1;
		sticky  = |(sig_q & smask);
		qr      = shifted[54:1] + {53'd0, guard & (sticky | shifted[1])};
		if (qr[53]) begin
			qn   = qr >> 1;
			tn_r = tc_r + exp_t'(1);
		end else begin
			qn   = qr;
			tn_r = tc_r;
		end
		biased_r = tn_r + exp_t'(1075);
		if (qn[52]) begin
			if (biased_r >= exp_t'(2047)) begin
				rnd_res = {sign_q_w, 11'h7FF, 52'd0};
			end else begin
				rnd_res = {sign_q_w, biased_r[10:0], qn[51:0]};
			end
		end else begin
			rnd_res = {sign_q_w, 11'd0, qn[51:0]};
		end
	end

	logic unp_done;
	assign unp_done = ma_q[52] && mb_q[52] && (czero_q || mc_q[52]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				F_IDLE: begin
					if (req.start) begin
						if (spec_hit) begin
							done_q <= 1'b1;
						end else begin
							state_q <= F_UNP;
						end
					end
				end
				F_UNP: if (unp_done) state_q <= F_MUL;
				F_MUL: if (cnt_q == 3'd6) state_q <= F_ALN;
				F_ALN: state_q <= czero_q ? F_NRM : F_ADD;
				F_ADD: state_q <= F_FIX;
				F_FIX: begin
					if (sub_q && (sum_q == '0)) begin
						done_q  <= 1'b1;
						state_q <= F_IDLE;
					end else begin
						state_q <= F_NRM;
					end
				end
				F_NRM: if (sig_q[127]) state_q <= F_RND;
				F_RND: begin
					done_q  <= 1'b1;
					state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (req.start) begin
					res_q   <= spec_res;
					sp_q    <= sp_in;
					sc_q    <= sc_in;
					sub_q   <= sp_in ^ sc_in;
					czero_q <= f_zero(req.c);
					ma_q    <= {|req.a[62:52], req.a[51:0]};
					mb_q    <= {|req.b[62:52], req.b[51:0]};
					mc_q    <= {|req.c[62:52], req.c[51:0]};
					ea_q    <= (|req.a[62:52]) ? exp_t'({3'd0, req.a[62:52]}) - exp_t'(1075)
						: exp_t'(-1074);
					eb_q    <= (|req.b[62:52]) ? exp_t'({3'd0, req.b[62:52]}) - exp_t'(1075)
						: exp_t'(-1074);
					ec_q    <= (|req.c[62:52]) ? exp_t'({3'd0, req.c[62:52]}) - exp_t'(1075)
						: exp_t'(-1074);
				end
			end
			F_UNP: begin
				// Subnormal inputs are brought to a leading one, eight bits at a time
				// while the top byte is clear, then one bit at a time.
				if (!ma_q[52]) begin
					if (ma_q[52:45] == '0) begin
						ma_q <= ma_q << 8;
						ea_q <= ea_q - exp_t'(8);
					end else begin
						ma_q <= ma_q << 1;
						ea_q <= ea_q - exp_t'(1);
					end
				end
				if (!mb_q[52]) begin
					if (mb_q[52:45] == '0) begin
						mb_q <= mb_q << 8;
						eb_q <= eb_q - exp_t'(8);
					end else begin
						mb_q <= mb_q << 1;
						eb_q <= eb_q - exp_t'(1);
					end
				end
				if (!czero_q && !mc_q[52]) begin
					if (mc_q[52:45] == '0) begin
						mc_q <= mc_q << 8;
						ec_q <= ec_q - exp_t'(8);
					end else begin
						mc_q <= mc_q << 1;
						ec_q <= ec_q - exp_t'(1);
					end
				end
				acc_q  <= '0;
				cnt_q  <= '0;
				mbsh_q <= {3'd0, mb_q};
			end
			F_MUL: begin
				// One byte of the multiplier per cycle, most significant first.
				acc_q  <= (acc_q << 8) + 128'({8'd0, ma_q} * {53'd0, mbsh_q[55:48]});
				mbsh_q <= mbsh_q << 8;
				cnt_q  <= cnt_q + 3'd1;
			end
			F_ALN: begin
				if (czero_q) begin
					sig_q  <= p_al;
					e_q    <= ep_al;
					sign_q <= sp_q;
				end else if (p_ge) begin
					acc_q <= p_al;
					cs_q  <= jammed;
					e_q   <= ep_al;
				end else begin
					acc_q <= jammed;
					cs_q  <= c_al;
					e_q   <= ecs_al;
				end
			end
			F_ADD: begin
				sum_q <= sub_q ? ({1'b0, acc_q} - {1'b0, cs_q}) : ({1'b0, acc_q} + {1'b0, cs_q});
			end
			F_FIX: begin
				if (sub_q && (sum_q == '0)) begin
					res_q <= 64'd0;
				end else if (sub_q && sum_q[128]) begin
					sig_q  <= -sum_q[127:0];
					sign_q <= sc_q;
				end else begin
					sig_q  <= sum_q[127:0];
					sign_q <= sp_q;
				end
			end
			F_NRM: begin
				if (!sig_q[127]) begin
					if (sig_q[127:120] == '0) begin
						sig_q <= sig_q << 8;
						e_q   <= e_q - exp_t'(8);
					end else begin
						sig_q <= sig_q << 1;
						e_q   <= e_q - exp_t'(1);
					end
				end
			end
			F_RND: res_q <= rnd_res;
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

endmodule
`default_nettype wire

[hdl/matrix_multiply_accumulate.sv]
// Top level: three element memories, APB size register and the compute sequencer.
// Depends on mma_pkg, mma_fma and matrix_multiply_accumulate_defines.svh.
`default_nettype none
`include "matrix_multiply_accumulate_defines.svh"

// Writes of A, B or C take effect at the accepting edge and leave busy low. A read
// of C raises busy for one cycle and presents the word on the result ports, with
// strobe high, in the cycle after it was accepted; the receiver cannot stall it.
// A compute walks all n^3 terms, n being size capped at MAX_N, through one
// iterative fused multiply-add unit. Each term loads A and B, starts the unit
// and waits on it; C is loaded once per element. For ordinary operands the unit
// unpacks, takes 7 multiply steps, aligns, adds, fixes the sign, normalizes and
// rounds; a zero addend skips add and sign fix, and a subnormal operand adds
// unpack steps. Busy stays high throughout.
module matrix_multiply_accumulate #(
	parameter int MAX_N = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  operation,
	input  wire logic [3:0]  row,
	input  wire logic [3:0]  col,
	input  wire logic [63:0] value,
	output logic             strobe,
	output logic      [3:0]  row_out,
	output logic      [3:0]  col_out,
	output logic      [63:0] result_value
);
	import mma_pkg::*;

	localparam int DEPTH = MAX_N * MAX_N;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = (MAX_N > 1) ? $clog2(MAX_N) : 1;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b00_0001,
		ST_RD   = 6'b00_0010,
		ST_LDC  = 6'b00_0100,
		ST_LDAB = 6'b00_1000,
		ST_GO   = 6'b01_0000,
		ST_WAIT = 6'b10_0000
	} state_t;

	state_t        state_q;
	logic [4:0]    size_q;
	logic [CW:0]   n_q;
	logic [CW-1:0] i_q, j_q, k_q;
	logic          first_q;
	logic [63:0]   acc_q;
	logic [3:0]    row_q, col_q;
	logic          in_rng_q;

	logic [63:0] mem_a [DEPTH];
	logic [63:0] mem_b [DEPTH];
	logic [63:0] mem_c [DEPTH];
	logic [63:0] a_rd_q, b_rd_q, c_rd_q;

	fma_req_t fma_req;
	fma_rsp_t fma_rsp;

	logic          accept, cfg_wr, in_rng, last_k;
	logic [AW-1:0] in_addr, a_addr, b_addr, cc_addr, c_raddr, c_waddr;
	logic          c_we;
	logic [63:0]   c_wdata;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr == 3'd0) ? {27'd0, size_q} : 32'd0;

	assign in_rng  = (32'(row) < MAX_N) && (32'(col) < MAX_N);
	assign in_addr = AW'(32'(col) * 32'(MAX_N) + 32'(row));
	assign a_addr  = AW'(32'(k_q) * 32'(MAX_N) + 32'(i_q));
	assign b_addr  = AW'(32'(j_q) * 32'(MAX_N) + 32'(k_q));
	assign cc_addr = AW'(32'(j_q) * 32'(MAX_N) + 32'(i_q));
	assign c_raddr = (state_q == ST_IDLE) ? in_addr : cc_addr;
	assign last_k  = ({1'b0, k_q} + (CW+1)'(1)) == n_q;

	always_comb begin
		c_we    = 1'b0;
		c_waddr = in_addr;
		c_wdata = value;
		if (state_q == ST_IDLE) begin
			c_we = accept && (operation == OP_WR_C) && in_rng;
		end else if ((state_q == ST_WAIT) && fma_rsp.done && last_k) begin
			c_we    = 1'b1;
			c_waddr = cc_addr;
			c_wdata = fma_rsp.res;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (operation == OP_WR_A) && in_rng) mem_a[in_addr] <= value;
		if (accept && (operation == OP_WR_B) && in_rng) mem_b[in_addr] <= value;
		if (c_we) mem_c[c_waddr] <= c_wdata;
		a_rd_q <= mem_a[a_addr];
		b_rd_q <= mem_b[b_addr];
		c_rd_q <= mem_c[c_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= 5'd16;
		end else if (cfg_wr && (paddr == 3'd0)) begin
			size_q <= pwdata[4:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			n_q     <= '0;
			first_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (operation == OP_RD_C)) begin
						state_q <= ST_RD;
					end else if (accept && (operation == OP_COMPUTE) && (size_q != 5'd0)) begin
						n_q     <= (32'(size_q) > MAX_N) ? (CW+1)'(MAX_N) : (CW+1)'(size_q);
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= ST_LDC;
					end
				end
				ST_RD: state_q <= ST_IDLE;
				ST_LDC: begin
					first_q <= 1'b1;
					state_q <= ST_LDAB;
				end
				ST_LDAB: state_q <= ST_GO;
				ST_GO: begin
					first_q <= 1'b0;
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (fma_rsp.done) begin
						if (last_k) begin
							k_q <= '0;
							if (({1'b0, i_q} + (CW+1)'(1)) == n_q) begin
								i_q <= '0;
								if (({1'b0, j_q} + (CW+1)'(1)) == n_q) begin
									state_q <= ST_IDLE;
								end else begin
									j_q     <= j_q + CW'(1);
									state_q <= ST_LDC;
								end
							end else begin
								i_q     <= i_q + CW'(1);
								state_q <= ST_LDC;
							end
						end else begin
							k_q     <= k_q + CW'(1);
							state_q <= ST_LDAB;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The running sum starts from the stored C word and then follows the unit.
	always_ff @(posedge clk) begin
		if ((state_q == ST_LDAB) && first_q) acc_q <= c_rd_q;
		if ((state_q == ST_WAIT) && fma_rsp.done) acc_q <= fma_rsp.res;
		if (accept) begin
			row_q    <= row;
			col_q    <= col;
			in_rng_q <= in_rng;
		end
	end

	assign fma_req.start = (state_q == ST_GO);
	assign fma_req.a     = a_rd_q;
	assign fma_req.b     = b_rd_q;
	assign fma_req.c     = acc_q;

	mma_fma u_fma (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fma_req),
		.rsp    (fma_rsp)
	);

	assign strobe       = (state_q == ST_RD);
	assign row_out      = row_q;
	assign col_out      = col_q;
	assign result_value = in_rng_q ? c_rd_q : 64'd0;

	`MMA_ASSERT_NEXT(a_read_gives_word, start && !busy && operation == OP_RD_C, strobe, "read word missing")
	`MMA_ASSERT_NOW(a_strobe_while_busy, strobe, busy, "word shown while idle")
	`MMA_ASSERT_NOW(a_fma_done_in_wait, fma_rsp.done, state_q == ST_WAIT, "unit finished unexpectedly")

endmodule
`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for the matrix multiply-accumulate block.
// Depends on mma_pkg and matrix_multiply_accumulate; drives words and APB writes,
// and predicts C reads with a bit-exact binary64 FMA model or a directed word.
`default_nettype none

module tb;
	import mma_pkg::*;

	localparam int          DIM          = 16;
	localparam logic [2:0]  SIZE_ADDR    = 3'd0;
	localparam logic [2:0]  OP_SPARE_LO  = 3'd5;
	localparam logic [2:0]  OP_SPARE_HI  = 3'd7;
	localparam logic [63:0] HIDDEN       = 64'h0010_0000_0000_0000;
	localparam logic [63:0] POS_INF      = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] MAX_FINITE   = 64'h7FEF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ONE          = 64'h3FF0_0000_0000_0000;
	localparam int          PHASE_ITEMS  = 90;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  operation = '0;
	logic [3:0]  row = '0, col = '0;
	logic [63:0] value = '0;
	logic        strobe;
	logic [3:0]  row_out, col_out;
	logic [63:0] result_value;

	matrix_multiply_accumulate dut (.*);

	always #1 clk = ~clk;

	typedef struct packed {
		logic [3:0]  r;
		logic [3:0]  c;
		logic [63:0] v;
	} c_word_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [3:0]  r;
		logic [3:0]  c;
		logic [63:0] v;
		logic        typed;
		logic [63:0] want;
	} step_t;

	// Predicted block state, column-major like the block.
	logic [63:0] mat_a [DIM*DIM];
	logic [63:0] mat_b [DIM*DIM];
	logic [63:0] mat_c [DIM*DIM];
	bit          wr_a [DIM*DIM];
	bit          wr_b [DIM*DIM];
	bit          wr_c [DIM*DIM];
	logic [4:0]  size_reg = 5'd16;

	c_word_t     c_reads_due [$];
	c_word_t     got;
	int          sender_idle = 0;
	int          mismatches = 0;
	int          items = 0, reads_checked = 0, computes = 0;

	function automatic logic [127:0] shr_sticky(logic [127:0] x, int s);
		logic [127:0] r;
		r = x >> s;
		if (s > 0 && (x & ((128'd1 << s) - 128'd1)) != 0)
			r[0] = 1'b1;
		return r;
	endfunction

	function automatic logic [63:0] round_to_double(logic sgn, logic [127:0] sig, int e);
		int          m, t, sh, biased;
		logic [127:0] moved;
		logic [63:0] q;
		logic        guard, sticky;
		m = 127;
		while (m > 0 && !sig[m])
			m--;
		t = m + e - 52;
		if (t < -1074)
			t = -1074;
		sh = t - e;
		if (sh <= 0) begin
			moved = sig << (-sh);
			q = moved[63:0];
		end else begin
			if (sh > 200)
				sh = 200;
			guard = (sh - 1 < 128) ? sig[sh-1] : 1'b0;
			sticky = (sig & ((128'd1 << (sh - 1)) - 128'd1)) != 0;
			moved = sig >> sh;
			q = moved[63:0];
			if (guard && (sticky || q[0]))
				q++;
		end
		if (q == (HIDDEN << 1)) begin
			q = q >> 1;
			t++;
		end
		if (q >= HIDDEN) begin
			biased = t + 1075;
			if (biased >= 2047)
				return {sgn, 11'h7FF, 52'd0};
			return {sgn, biased[10:0], q[51:0]};
		end
		return {sgn, q[62:0]};
	endfunction

	function automatic void split_double(input logic [63:0] x, output logic [63:0] m,
			output int e);
		if (x[62:52] == 11'd0) begin
			m = {12'd0, x[51:0]};
			e = -1074;
			while (m < HIDDEN) begin
				m = m << 1;
				e--;
			end
		end else begin
			m = {11'd0, 1'b1, x[51:0]};
			e = int'(x[62:52]) - 1075;
		end
	endfunction

	function automatic bit is_nan(logic [63:0] x);
		return x[62:52] == 11'h7FF && x[51:0] != 0;
	endfunction

	function automatic bit is_inf(logic [63:0] x);
		return x[62:0] == POS_INF[62:0];
	endfunction

	function automatic bit is_zero(logic [63:0] x);
		return x[62:0] == 0;
	endfunction

	// a*b + c with a single rounding, nearest even.
	function automatic logic [63:0] fused_mac(logic [63:0] a, logic [63:0] b, logic [63:0] c);
		logic        sp, sc;
		logic [63:0] ma, mb, mc;
		int          ea, eb, ec, ep, d;
		logic [127:0] p, cs;
		sp = a[63] ^ b[63];
		sc = c[63];
		if (is_nan(a)) return a | QUIET_BIT;
		if (is_nan(b)) return b | QUIET_BIT;
		if (is_nan(c)) return c | QUIET_BIT;
		if (is_inf(a) || is_inf(b)) begin
			if (is_zero(a) || is_zero(b)) return DEFAULT_NAN;
			if (is_inf(c) && sc != sp) return DEFAULT_NAN;
			return {sp, POS_INF[62:0]};
		end
		if (is_inf(c)) return c;
		if (is_zero(a) || is_zero(b)) begin
			if (!is_zero(c)) return c;
			return (sp == sc) ? {sp, 63'd0} : 64'd0;
		end
		split_double(a, ma, ea);
		split_double(b, mb, eb);
		p = (128'(ma) * 128'(mb)) << 20;
		ep = ea + eb - 20;
		if (is_zero(c))
			return round_to_double(sp, p, ep);
		split_double(c, mc, ec);
		cs = 128'(mc) << 72;
		ec = ec - 72;
		if (ep >= ec) begin
			d = ep - ec;
			cs = shr_sticky(cs, d > 200 ? 200 : d);
		end else begin
			d = ec - ep;
			p = shr_sticky(p, d > 200 ? 200 : d);
			ep = ec;
		end
		if (sp == sc)
			return round_to_double(sp, p + cs, ep);
		if (p > cs)
			return round_to_double(sp, p - cs, ep);
		if (p < cs)
			return round_to_double(sc, cs - p, ep);
		return 64'd0;
	endfunction

	function automatic void multiply_accumulate();
		int          n;
		logic [63:0] acc;
		n = (size_reg > DIM) ? DIM : int'(size_reg);
		for (int j = 0; j < n; j++)
			for (int i = 0; i < n; i++) begin
				acc = mat_c[j*DIM + i];
				for (int k = 0; k < n; k++)
					acc = fused_mac(mat_a[k*DIM + i], mat_b[j*DIM + k], acc);
				mat_c[j*DIM + i] = acc;
			end
	endfunction

	function automatic void track_word(step_t s);
		int idx;
		idx = int'(s.c) * DIM + int'(s.r);
		case (s.op)
			OP_WR_A: begin mat_a[idx] = s.v; wr_a[idx] = 1; end
			OP_WR_B: begin mat_b[idx] = s.v; wr_b[idx] = 1; end
			OP_WR_C: begin mat_c[idx] = s.v; wr_c[idx] = 1; end
			OP_COMPUTE: begin
				multiply_accumulate();
				computes++;
			end
			OP_RD_C: c_reads_due.push_back({s.r, s.c, s.typed ? s.want : mat_c[idx]});
			default: ;
		endcase
		if (s.op < OP_SPARE_LO)
			items++;
	endfunction

	function automatic logic [63:0] pick_double();
		logic [63:0] x;
		x = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: x[62:52] = 11'($urandom_range(1003, 1043));
			6: ;
			7: case ($urandom_range(0, 6))
				0: x = 64'd0;
				1: x = {1'b1, 63'd0};
				2: x = {x[63], POS_INF[62:0]};
				3: x = {x[63], 12'hFFF, x[50:0]};
				4: x = {x[63], 11'h7FF, 1'b0, x[50:1], 1'b1};
				5: x = {x[63], MAX_FINITE[62:0]};
				default: x = {x[63], 11'd0, x[51:0]};
			endcase
			8: x[62:52] = 11'($urandom_range(2000, 2046));
			default: x[62:52] = 11'($urandom_range(0, 40));
		endcase
		return x;
	endfunction

	task automatic issue(step_t s);
		start <= 1'b1;
		operation <= s.op;
		row <= s.r;
		col <= s.c;
		value <= s.v;
		do
			@(posedge clk);
		while (busy);
		track_word(s);
		if ($urandom_range(0, 99) < sender_idle) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic issue_op(logic [2:0] op, logic [3:0] r, logic [3:0] c, logic [63:0] v);
		issue({op, r, c, v, 1'b0, 64'd0});
	endtask

	task automatic drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (busy || c_reads_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_size(logic [4:0] n);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= SIZE_ADDR;
		pwdata <= 32'(n);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		size_reg = n;
	endtask

	// Every operand of the leading part must be written before a compute.
	task automatic fill_leading();
		int n;
		n = (size_reg > DIM) ? DIM : int'(size_reg);
		for (int j = 0; j < n; j++)
			for (int i = 0; i < n; i++) begin
				if (!wr_a[j*DIM + i]) issue_op(OP_WR_A, 4'(i), 4'(j), pick_double());
				if (!wr_b[j*DIM + i]) issue_op(OP_WR_B, 4'(i), 4'(j), pick_double());
				if (!wr_c[j*DIM + i]) issue_op(OP_WR_C, 4'(i), 4'(j), pick_double());
			end
	endtask

	task automatic random_phase(logic [4:0] n);
		logic [3:0] r, c;
		int         pick;
		bit         big_done;
		big_done = 0;
		for (int k = 0; k < PHASE_ITEMS; k++) begin
			r = 4'($urandom);
			c = 4'($urandom);
			pick = $urandom_range(0, 99);
			if (n > 6 && k == PHASE_ITEMS / 2 && !big_done) begin
				fill_leading();
				issue_op(OP_COMPUTE, r, c, pick_double());
				big_done = 1;
			end else if (pick < 4 && n <= 6) begin
				fill_leading();
				issue_op(OP_COMPUTE, r, c, pick_double());
			end else if (pick < 7) begin
				issue_op(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), r, c, pick_double());
			end else if (pick < 42) begin
				if (!wr_c[int'(c)*DIM + int'(r)])
					issue_op(OP_WR_C, r, c, pick_double());
				issue_op(OP_RD_C, r, c, pick_double());
			end else begin
				issue_op(3'($urandom_range(OP_WR_A, OP_WR_C)), r, c, pick_double());
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (c_reads_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected C word: row %0d col %0d value %h",
						row_out, col_out, result_value);
			end else begin
				got = c_reads_due.pop_front();
				reads_checked++;
				if (got.r !== row_out || got.c !== col_out || got.v !== result_value) begin
					mismatches++;
					if (mismatches <= 10)
						$display("C word mismatch: expected (%0d,%0d) %h, got (%0d,%0d) %h",
							got.r, got.c, got.v, row_out, col_out, result_value);
				end
			end
		end
	end

	initial begin
		#20000000;
		$display("matrix_multiply_accumulate regression: fail");
		$finish;
	end

	initial begin
		step_t      plan [24];
		logic [4:0] sizes [14];
		plan = '{
			'{OP_WR_C, 4'd0, 4'd0, 64'd0, 1'b0, 64'd0},
			'{OP_RD_C, 4'd0, 4'd0, 64'd0, 1'b1, 64'd0},
			'{OP_WR_C, 4'd15, 4'd15, '1, 1'b0, 64'd0},
			'{OP_RD_C, 4'd15, 4'd15, 64'd0, 1'b1, '1},
			'{OP_WR_C, 4'd1, 4'd0, {1'b1, 63'd0}, 1'b0, 64'd0},
			'{OP_RD_C, 4'd1, 4'd0, '1, 1'b1, {1'b1, 63'd0}},
			'{OP_SPARE_LO, 4'd3, 4'd3, '1, 1'b0, 64'd0},
			'{OP_SPARE_HI, 4'd0, 4'd0, 64'd0, 1'b0, 64'd0},
			'{OP_WR_A, 4'd0, 4'd0, ONE, 1'b0, 64'd0},
			'{OP_WR_A, 4'd1, 4'd0, POS_INF, 1'b0, 64'd0},
			'{OP_WR_A, 4'd0, 4'd1, 64'd1, 1'b0, 64'd0},
			'{OP_WR_A, 4'd1, 4'd1, MAX_FINITE, 1'b0, 64'd0},
			'{OP_WR_B, 4'd0, 4'd0, 64'h4000_0000_0000_0000, 1'b0, 64'd0},
			'{OP_WR_B, 4'd1, 4'd0, 64'd0, 1'b0, 64'd0},
			'{OP_WR_B, 4'd0, 4'd1, {1'b1, ONE[62:0]}, 1'b0, 64'd0},
			'{OP_WR_B, 4'd1, 4'd1, ONE, 1'b0, 64'd0},
			'{OP_WR_C, 4'd0, 4'd1, POS_INF, 1'b0, 64'd0},
			'{OP_WR_C, 4'd1, 4'd1, 64'h7FF0_0000_0000_0001, 1'b0, 64'd0},
			'{OP_COMPUTE, 4'd0, 4'd0, 64'd0, 1'b0, 64'd0},
			'{OP_RD_C, 4'd0, 4'd0, 64'd0, 1'b0, 64'd0},
			'{OP_RD_C, 4'd1, 4'd0, 64'd0, 1'b0, 64'd0},
			'{OP_RD_C, 4'd0, 4'd1, 64'd0, 1'b0, 64'd0},
			'{OP_RD_C, 4'd1, 4'd1, 64'd0, 1'b0, 64'd0},
			'{OP_RD_C, 4'd15, 4'd15, 64'd0, 1'b0, 64'd0}
		};
		sizes = '{5'd1, 5'd3, 5'd4, 5'd0, 5'd2, 5'd5, 5'd16, 5'd3, 5'd6,
			5'd31, 5'd1, 5'd4, 5'd2, 5'd3};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_size(5'd2);
		foreach (plan[i])
			issue(plan[i]);
		drain();
		foreach (sizes[p]) begin
			if (p < 5)
				sender_idle = 19;
			else if (p < 10)
				sender_idle = 78;
			else
				sender_idle = 0;
			set_size(sizes[p]);
			random_phase(sizes[p]);
			drain();
		end
		repeat (20) @(posedge clk);
		if (c_reads_due.size() != 0)
			mismatches++;
		$display("Ran %0d words over %0d size settings, %0d computes, %0d C reads checked.",
			items, $size(sizes) + 1, computes, reads_checked);
		if (mismatches == 0)
			$display("matrix_multiply_accumulate regression: pass");
		else
			$display("matrix_multiply_accumulate regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
